// ===== rtl/modular_exponentiation_core_defines.svh =====
// Assertion macros shared by the verification code of the modular exponentiation core.
`ifndef MODULAR_EXPONENTIATION_CORE_DEFINES_SVH
`define MODULAR_EXPONENTIATION_CORE_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define MEXP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define MEXP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/mexp_pkg.sv =====
package mexp_pkg;

  localparam int unsigned OPERAND_W     = 32;
  localparam int unsigned RESULT_W      = 32;
  localparam int unsigned MODULUS_W     = 32;
  localparam logic [MODULUS_W-1:0] MODULUS_RESET = 32'd1000000007;
  localparam int unsigned FERMAT_OFFSET = 2;

  typedef enum logic {
    OP_POWER   = 1'b0,
    OP_INVERSE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BASE,
    S_STEP,
    S_ACC,
    S_SQR,
    S_OUT
  } state_e;

  // Request from the sequencer to the shared multiply-reduce unit.
  typedef struct packed {
    logic start;
    logic raw;
    logic use_acc;
  } mexp_req_t;

  // Status back from the multiply-reduce unit.
  typedef struct packed {
    logic busy;
    logic done;
  } mexp_sts_t;

endpackage

// ===== rtl/mexp_intf.sv =====
interface mexp_req_if import mexp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 op;
  logic [OPERAND_W-1:0] base;
  logic [OPERAND_W-1:0] exponent;

  modport source (output valid, output op, output base, output exponent, input ready);
  modport sink (input valid, input op, input base, input exponent, output ready);
endinterface

interface mexp_rsp_if import mexp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [RESULT_W-1:0] result;

  modport source (output valid, output result, input ready);
  modport sink (input valid, input result, output ready);
endinterface

interface mexp_cfg_if import mexp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [MODULUS_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/mexp_modmul.sv =====
// Shared modular multiplier: one product per request, then a restoring
// reduction that retires two dividend bits per cycle.
module mexp_modmul import mexp_pkg::*; #(
  parameter int unsigned MOD_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mexp_req_t            req_i,
  input  logic [MOD_BITS-1:0]  a_i,
  input  logic [MOD_BITS-1:0]  b_i,
  input  logic [OPERAND_W-1:0] raw_i,
  input  logic [MOD_BITS-1:0]  mod_i,
  output mexp_sts_t            sts_o,
  output logic [MOD_BITS-1:0]  res_o
);

  localparam int unsigned PROD_W    = 2 * MOD_BITS;
  localparam int unsigned RED_W     = (PROD_W > OPERAND_W) ? PROD_W : OPERAND_W;
  localparam int unsigned RED_STEPS = RED_W / 2;
  localparam int unsigned CNT_W     = $clog2(RED_STEPS + 1);

  logic [PROD_W-1:0]   prod;
  logic [RED_W-1:0]    x_q;
  logic [MOD_BITS-1:0] r_q, r_d;
  logic [CNT_W-1:0]    cnt_q;
  logic                busy_q, done_q;
  logic [MOD_BITS:0]   t1, t2;
  logic [MOD_BITS-1:0] r1;

  assign prod = a_i * b_i;

  // Two dependent shift-compare-subtract steps.
  always_comb begin
    t1 = {r_q, x_q[RED_W-1]};
    if (t1 >= {1'b0, mod_i}) begin
      t1 = t1 - {1'b0, mod_i};
    end
    r1 = t1[MOD_BITS-1:0];
    t2 = {r1, x_q[RED_W-2]};
    if (t2 >= {1'b0, mod_i}) begin
      t2 = t2 - {1'b0, mod_i};
    end
    r_d = t2[MOD_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= !req_i.start && busy_q && (cnt_q == CNT_W'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q   <= req_i.raw ? RED_W'(raw_i) : RED_W'(prod);
      r_q   <= '0;
      cnt_q <= CNT_W'(RED_STEPS);
    end else if (busy_q) begin
      x_q   <= x_q << 2;
      r_q   <= r_d;
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign res_o      = r_q;

endmodule

// ===== rtl/modular_exponentiation_core.sv =====
// Modular exponentiation core. Each request transfer carries an op, a base and an
// exponent; the core returns base^exponent mod modulus (op power) or
// base^(modulus-2) mod modulus (op inverse, the Fermat inverse when the modulus is
// prime; primality is not checked). The modulus is a configuration register, reset
// to 1000000007, written through the cfg channel; the user must write it only while
// the core is idle, which the core itself does not enforce. Only the low MOD_BITS
// bits of the modulus are used, and a modulus below 2 gives a result of 0. The
// exponent is scanned from its least significant bit over EXP_BITS bits. All work
// runs through one shared multiply-reduce unit, which forms the product, reduces
// it two bits at a time over RED_W bits, where RED_W is the larger of 2*MOD_BITS
// and 32, and then hands back the remainder. The base is reduced first, starting
// with the request transfer. Every exponent bit then takes a squaring and, when the
// bit is set, a multiply into the accumulator issued just before it; the squaring
// after the last bit is skipped, and the S_OUT state then moves the result to the
// output register. The core takes no new request while an item is in work; a
// finished result waits in an output register, and the core returns to idle as
// soon as that register is free.
module modular_exponentiation_core import mexp_pkg::*; #(
  parameter int unsigned EXP_BITS = 32,
  parameter int unsigned MOD_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mexp_req_if.sink   req_i,
  mexp_rsp_if.source rsp_o,
  mexp_cfg_if.sink   cfg_i
);

  localparam int unsigned CNT_W = $clog2(EXP_BITS + 1);

  state_e               state_q, state_d;
  mexp_req_t            mm_req;
  mexp_sts_t            mm_sts;
  logic [MOD_BITS-1:0]  mm_res;
  logic [MOD_BITS-1:0]  mm_a;

  logic [MODULUS_W-1:0] mod_q;
  logic [MOD_BITS-1:0]  m;
  logic                 m_small;

  logic [MOD_BITS-1:0]  acc_q;
  logic [MOD_BITS-1:0]  sq_q;
  logic [EXP_BITS-1:0]  e_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [RESULT_W-1:0]  result_q;
  logic                 rsp_valid_q;
  logic                 req_xfer;
  logic                 rsp_load;

  // Configuration register, always ready: write only while idle; nothing enforces it.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= MODULUS_RESET;
    end else if (cfg_i.valid) begin
      mod_q <= cfg_i.data;
    end
  end

  assign m       = mod_q[MOD_BITS-1:0];
  assign m_small = (m < MOD_BITS'(2));

  assign req_i.ready = (state_q == S_IDLE);
  assign req_xfer    = req_i.valid && req_i.ready;
  assign rsp_load    = (state_q == S_OUT) && (state_d == S_IDLE);

  // Sequencer: reduce the base, then walk the exponent bits one at a time; a modulus below 2 goes straight to S_OUT.
  always_comb begin
    state_d        = state_q;
    mm_req.start   = 1'b0;
    mm_req.raw     = 1'b0;
    mm_req.use_acc = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          if (m_small) begin
            state_d = S_OUT;
          end else begin
            mm_req.start = 1'b1;
            mm_req.raw   = 1'b1;
            state_d      = S_BASE;
          end
        end
      end
      S_BASE: begin
        if (mm_sts.done) begin
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        if (cnt_q == '0) begin
          state_d = S_OUT;
        end else if (e_q[0]) begin
          mm_req.start   = 1'b1;
          mm_req.use_acc = 1'b1;
          state_d        = S_ACC;
        end else if (cnt_q != CNT_W'(1)) begin
          // The square after the last bit would never be used, so it is skipped.
          mm_req.start = 1'b1;
          state_d      = S_SQR;
        end
      end
      S_ACC: begin
        if (mm_sts.done) begin
          state_d = S_STEP;
        end
      end
      S_SQR: begin
        if (mm_sts.done) begin
          state_d = S_STEP;
        end
      end
      S_OUT: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers of the exponentiation.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (req_xfer) begin
          // With a modulus below 2 the accumulator is forced to 0 and sent directly.
          acc_q <= m_small ? '0 : MOD_BITS'(1);
          cnt_q <= CNT_W'(EXP_BITS);
          if (op_e'(req_i.op) == OP_INVERSE) begin
            e_q <= EXP_BITS'(m - MOD_BITS'(FERMAT_OFFSET));
          end else begin
            e_q <= EXP_BITS'(req_i.exponent);
          end
        end
      end
      S_BASE: begin
        if (mm_sts.done) begin
          sq_q <= mm_res;
        end
      end
      S_STEP: begin
        if (cnt_q != '0 && !e_q[0] && cnt_q == CNT_W'(1)) begin
          cnt_q <= '0;
        end
      end
      S_ACC: begin
        if (mm_sts.done) begin
          acc_q  <= mm_res;
          e_q[0] <= 1'b0;
        end
      end
      S_SQR: begin
        if (mm_sts.done) begin
          sq_q  <= mm_res;
          e_q   <= e_q >> 1;
          cnt_q <= cnt_q - CNT_W'(1);
        end
      end
      S_OUT: begin
        if (rsp_load) begin
          result_q <= RESULT_W'(acc_q);
        end
      end
      default: begin
      end
    endcase
  end

  assign mm_a = mm_req.use_acc ? acc_q : sq_q;

  mexp_modmul #(
    .MOD_BITS(MOD_BITS)
  ) u_modmul (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mm_req),
    .a_i   (mm_a),
    .b_i   (sq_q),
    .raw_i (req_i.base),
    .mod_i (m),
    .sts_o (mm_sts),
    .res_o (mm_res)
  );

  assign rsp_o.valid  = rsp_valid_q;
  assign rsp_o.result = result_q;

endmodule

// ===== rtl/mexp_checker.sv =====
`include "modular_exponentiation_core_defines.svh"

module mexp_checker import mexp_pkg::*; #(
  parameter int unsigned MOD_BITS = 32
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic [RESULT_W-1:0]  result_i,
  input logic                 cfg_valid_i,
  input logic                 cfg_ready_i,
  input logic [MODULUS_W-1:0] cfg_data_i
);

  logic [MODULUS_W-1:0] shadow_q;
  logic [MOD_BITS-1:0]  shadow_m;

  // Copy of the modulus as seen on the configuration port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_q <= MODULUS_RESET;
    end else if (cfg_valid_i && cfg_ready_i) begin
      shadow_q <= cfg_data_i;
    end
  end

  assign shadow_m = shadow_q[MOD_BITS-1:0];

  `MEXP_ASSERT(a_busy_after_req, clk_i, rst_ni, (in_valid_i && in_ready_i) |=> !in_ready_i, "core ready again right after a request transfer")
  `MEXP_ASSERT(a_rsp_hold, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(result_i)), "stalled result dropped or changed")
  `MEXP_ASSERT(a_result_reduced, clk_i, rst_ni, (out_valid_i && shadow_m >= MOD_BITS'(2)) |-> (result_i < RESULT_W'(shadow_m)), "result not reduced by the modulus")
  `MEXP_ASSERT(a_small_mod_zero, clk_i, rst_ni, (out_valid_i && shadow_m < MOD_BITS'(2)) |-> (result_i == '0), "modulus below two must give zero")

endmodule

bind modular_exponentiation_core mexp_checker #(
  .MOD_BITS(MOD_BITS)
) u_mexp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (req_i.valid),
  .in_ready_i (req_i.ready),
  .out_valid_i(rsp_o.valid),
  .out_ready_i(rsp_o.ready),
  .result_i   (rsp_o.result),
  .cfg_valid_i(cfg_i.valid),
  .cfg_ready_i(cfg_i.ready),
  .cfg_data_i (cfg_i.data)
);
